### design/assert_macros.svh
// Assertion macros shared by the checker modules of this project.
// Needs a signal named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define SNR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication checked outside reset
`define SNR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

// Implication that also holds while reset is applied
`define SNR_ASSERT_ALW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("reset check failed");

`endif

### design/snr_pkg.sv
// Types and constants of the refraction pipeline.
// Used by the front stage, queue, back pipeline and top level.
`timescale 1ns / 1ps
package snr_pkg;

	localparam int RATIO_W = 31;   // quotient bits of eta_i * 2^16 / eta_t
	localparam int SQ_STEPS = 15;  // root bits of k in Q.28
	localparam logic [28:0] ONE_Q28 = 29'h1000_0000;

	// one classified ray hit as it crosses the queue
	typedef struct packed {
		logic [2:0][15:0] a;      // incident vector, signed Q2.14
		logic [2:0][16:0] n;      // normal after flip, signed
		logic [28:0]      c;      // |cosi|, Q.28
		logic [14:0]      eta_i;
		logic [14:0]      eta_t;  // never zero
	} snr_item_t;

	// divider stage contents
	typedef struct packed {
		snr_item_t        it;
		logic [14:0]      rem;
		logic [RATIO_W-1:0] q;
	} snr_div_t;

	// payload carried through the root stages
	typedef struct packed {
		logic [2:0][15:0]   a;
		logic [2:0][16:0]   n;
		logic [RATIO_W-1:0] ratio;
		logic [43:0]        coef0;  // floor(ratio*c) in Q.28
		logic               tir;
		logic [28:0]        rem;
		logic [14:0]        res;
	} snr_sq_t;

endpackage

### design/snr_front.sv
// Front stage: accepts hits, forms the clamped dot product, picks the side.
// Depends on snr_pkg.
`timescale 1ns / 1ps
module snr_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic signed [15:0]     inc_x,
	input  logic signed [15:0]     inc_y,
	input  logic signed [15:0]     inc_z,
	input  logic signed [15:0]     nrm_x,
	input  logic signed [15:0]     nrm_y,
	input  logic signed [15:0]     nrm_z,
	input  logic [14:0]            index_outside,
	input  logic [14:0]            index_inside,
	input  logic                   q_full,
	output logic                   q_push,
	output snr_pkg::snr_item_t     q_item
);
	import snr_pkg::*;

	logic                f_en;
	logic                v_s1, v_s2;
	logic signed [31:0]  px_s1, py_s1, pz_s1;
	logic [2:0][15:0]    a_s1, n_s1;
	logic [14:0]         ei_s1, et_s1;
	snr_item_t           item_s2, item_d;
	logic signed [33:0]  dot;
	logic signed [33:0]  cosi;
	logic [14:0]         et_sel;

	// whole front holds while the queue refuses its head
	assign f_en   = !(v_s2 && q_full);
	assign full   = !f_en;
	assign q_push = v_s2 && !q_full;
	assign q_item = item_s2;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (f_en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
		end
	end

	// stage 1: the three products
	always_ff @(posedge clk) begin
		if (f_en) begin
			px_s1 <= inc_x * nrm_x;
			py_s1 <= inc_y * nrm_y;
			pz_s1 <= inc_z * nrm_z;
			a_s1  <= {inc_z, inc_y, inc_x};
			n_s1  <= {nrm_z, nrm_y, nrm_x};
			ei_s1 <= index_outside;
			et_s1 <= index_inside;
		end
	end

	// stage 2: sum, clamp, entering or leaving
	always_comb begin
		dot = 34'(px_s1) + 34'(py_s1) + 34'(pz_s1);
		if (dot > $signed({5'b0, ONE_Q28}))
			cosi = $signed({5'b0, ONE_Q28});
		else if (dot < -$signed({5'b0, ONE_Q28}))
			cosi = -$signed({5'b0, ONE_Q28});
		else
			cosi = dot;
		item_d.a = a_s1;
		if (cosi < 0) begin
			item_d.c     = 29'(-cosi);
			item_d.eta_i = ei_s1;
			et_sel       = et_s1;
			for (int i = 0; i < 3; i++)
				item_d.n[i] = {n_s1[i][15], n_s1[i]};
		end else begin
			item_d.c     = cosi[28:0];
			item_d.eta_i = et_s1;
			et_sel       = ei_s1;
			for (int i = 0; i < 3; i++)
				item_d.n[i] = 17'(-$signed({n_s1[i][15], n_s1[i]}));
		end
		// zero divisor reads as the smallest code
		item_d.eta_t = (et_sel == 15'd0) ? 15'd1 : et_sel;
	end

	always_ff @(posedge clk) begin
		if (f_en)
			item_s2 <= item_d;
	end

endmodule

### design/snr_queue.sv
// Short queue of classified hits between the front and back parts.
// Depends on snr_pkg.
`timescale 1ns / 1ps
module snr_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  snr_pkg::snr_item_t wdata,
	output logic               full,
	input  logic               pop,
	output snr_pkg::snr_item_t rdata,
	output logic               empty
);
	import snr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	snr_item_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop && !empty)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if ((push && !full) && !(pop && !empty))
				cnt_q <= cnt_q + 1'b1;
			else if (!(push && !full) && (pop && !empty))
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### design/snr_back.sv
// Back pipeline: index ratio, k and its root, final vector and saturation.
// Depends on snr_pkg; holds the output register.
`timescale 1ns / 1ps
module snr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  snr_pkg::snr_item_t q_item,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z,
	output logic               total_internal
);
	import snr_pkg::*;

	logic en;
	logic out_v_q;

	// the whole back part moves when the output slot frees up
	assign en    = !out_v_q || pop;
	assign q_pop = en && !q_empty;
	assign empty = !out_v_q;

	// ---------------- divider: one quotient bit per stage ----------------
	snr_div_t div_s [RATIO_W+1];
	logic     div_v [RATIO_W+1];

	assign div_s[0] = '{it: q_item, rem: '0, q: '0};
	assign div_v[0] = !q_empty;

	for (genvar g = 0; g < RATIO_W; g++) begin : g_div
		localparam int J = RATIO_W - 1 - g;
		logic [RATIO_W-1:0] num;
		logic [15:0]        trial;
		snr_div_t           nxt;

		always_comb begin
			num   = {div_s[g].it.eta_i, 16'b0};
			trial = {div_s[g].rem, num[J]};
			nxt   = div_s[g];
			if (trial >= {1'b0, div_s[g].it.eta_t}) begin
				nxt.rem  = 15'(trial - {1'b0, div_s[g].it.eta_t});
				nxt.q[J] = 1'b1;
			end else begin
				nxt.rem = trial[14:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				div_v[g+1] <= 1'b0;
			else if (en)
				div_v[g+1] <= div_v[g];
		end

		always_ff @(posedge clk) begin
			if (en)
				div_s[g+1] <= nxt;
		end
	end

	// ---------------- squares and cross product ----------------
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [61:0]        r2f_s1;
	logic [57:0]        cc_s1;
	logic [59:0]        rc_s1;
	logic [RATIO_W-1:0] ratio_s1, ratio_s2, ratio_s3, ratio_s4;
	logic [2:0][15:0]   a_s1, a_s2, a_s3, a_s4;
	logic [2:0][16:0]   n_s1, n_s2, n_s3, n_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			r2f_s1   <= div_s[RATIO_W].q * div_s[RATIO_W].q;
			cc_s1    <= div_s[RATIO_W].it.c * div_s[RATIO_W].it.c;
			rc_s1    <= div_s[RATIO_W].q * div_s[RATIO_W].it.c;
			ratio_s1 <= div_s[RATIO_W].q;
			a_s1     <= div_s[RATIO_W].it.a;
			n_s1     <= div_s[RATIO_W].it.n;
		end
	end

	// ---------------- ratio^2 times (1 - cos^2), split product ----------------
	logic [56:0] s56;
	logic [28:0] s28;
	logic [45:0] r2;
	logic [57:0] plo_s2;
	logic [44:0] phi_s2;
	logic        big_s2;
	logic [43:0] coef0_s2, coef0_s3;

	// cos^2 reaches 2^56 for a unit cosine, so bit 56 is kept
	always_comb begin
		s56 = {1'b1, 56'b0} - cc_s1[56:0];
		s28 = s56[56:28];
		r2  = r2f_s1[61:16];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s2   <= r2[28:0] * s28;
			phi_s2   <= r2[44:29] * s28;
			big_s2   <= r2[45] && (s28 != '0);
			coef0_s2 <= rc_s1[59:16];
			ratio_s2 <= ratio_s1;
			a_s2     <= a_s1;
			n_s2     <= n_s1;
		end
	end

	// ---------------- k and the total internal reflection test ----------------
	logic [74:0] pfull;
	logic [58:0] prod28;
	logic        tir_s3;
	logic [28:0] k_s3;

	always_comb begin
		pfull  = {1'b0, phi_s2, 29'b0} + 75'(plo_s2);
		prod28 = pfull[74:16];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s3   <= big_s2 || (prod28 > 59'(ONE_Q28));
			k_s3     <= ONE_Q28 - prod28[28:0];
			coef0_s3 <= coef0_s2;
			ratio_s3 <= ratio_s2;
			a_s3     <= a_s2;
			n_s3     <= n_s2;
		end
	end

	// ---------------- square root: one result bit per stage ----------------
	snr_sq_t sq_s [SQ_STEPS+1];
	logic    sq_v [SQ_STEPS+1];

	assign sq_s[0] = '{a: a_s3, n: n_s3, ratio: ratio_s3, coef0: coef0_s3,
		tir: tir_s3, rem: k_s3, res: '0};
	assign sq_v[0] = v_s3;

	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
		localparam int I = SQ_STEPS - 1 - g;
		logic [30:0] t;
		snr_sq_t     nxt;

		always_comb begin
			t   = (31'(sq_s[g].res) << (I + 1)) + (31'(1) << (2 * I));
			nxt = sq_s[g];
			if ({2'b0, sq_s[g].rem} >= t) begin
				nxt.rem    = 29'({2'b0, sq_s[g].rem} - t);
				nxt.res[I] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v[g+1] <= 1'b0;
			else if (en)
				sq_v[g+1] <= sq_v[g];
		end

		always_ff @(posedge clk) begin
			if (en)
				sq_s[g+1] <= nxt;
		end
	end

	// ---------------- coefficient for the normal ----------------
	logic signed [44:0] coef_s4;
	logic               tir_s4, tir_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			coef_s4  <= $signed({1'b0, sq_s[SQ_STEPS].coef0})
				- $signed({16'b0, sq_s[SQ_STEPS].res, 14'b0});
			tir_s4   <= sq_s[SQ_STEPS].tir;
			ratio_s4 <= sq_s[SQ_STEPS].ratio;
			a_s4     <= sq_s[SQ_STEPS].a;
			n_s4     <= sq_s[SQ_STEPS].n;
		end
	end

	// ---------------- per-component products ----------------
	logic signed [47:0] pa_s5  [3];
	logic signed [39:0] nlo_s5 [3];
	logic signed [39:0] nhi_s5 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pa_s5[i]  <= $signed(a_s4[i]) * $signed({1'b0, ratio_s4});
				nlo_s5[i] <= $signed(n_s4[i]) * $signed({1'b0, coef_s4[21:0]});
				nhi_s5[i] <= $signed(n_s4[i]) * $signed(coef_s4[44:22]);
			end
			tir_s5 <= tir_s4;
		end
	end

	// ---------------- sum, round half up, saturate, zero on reflection ----------------
	logic signed [63:0] sum [3];
	logic signed [35:0] rnd [3];
	logic signed [15:0] sat [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = (64'(pa_s5[i]) <<< 12) + 64'(nlo_s5[i]) + (64'(nhi_s5[i]) <<< 22)
				+ 64'sd134217728;
			rnd[i] = 36'(sum[i] >>> 28);
			if (rnd[i] > 36'sd32767)
				sat[i] = 16'sh7fff;
			else if (rnd[i] < -36'sd32768)
				sat[i] = -16'sh8000;
			else
				sat[i] = rnd[i][15:0];
			if (tir_s5)
				sat[i] = '0;
		end
	end

	// valid chain of the arithmetic stages and the output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= div_v[RATIO_W];
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= sq_v[SQ_STEPS];
			v_s5    <= v_s4;
			out_v_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_x          <= sat[0];
			out_y          <= sat[1];
			out_z          <= sat[2];
			total_internal <= tir_s5;
		end
	end

endmodule

### design/snell_refraction_vector.sv
// Throughput: one hit per cycle while the output is not stalled, every stage
// pipelined; latency set mostly by the 31-stage divider and 15-stage root.
// Output stall freezes the back pipeline; a 4-entry queue absorbs front work.
// Reset: arst_n clears all valid bits and queue pointers; payload is not reset.
// Depends on snr_pkg, snr_front, snr_queue and snr_back.
`timescale 1ns / 1ps
module snell_refraction_vector #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] inc_x,
	input  logic signed [15:0] inc_y,
	input  logic signed [15:0] inc_z,
	input  logic signed [15:0] nrm_x,
	input  logic signed [15:0] nrm_y,
	input  logic signed [15:0] nrm_z,
	input  logic [14:0]        index_outside,
	input  logic [14:0]        index_inside,
	input  logic               pop,
	output logic               empty,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z,
	output logic               total_internal
);
	import snr_pkg::*;

	logic      q_full, q_empty, q_push, q_pop;
	snr_item_t q_wdata, q_rdata;

	snr_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.inc_x(inc_x), .inc_y(inc_y), .inc_z(inc_z),
		.nrm_x(nrm_x), .nrm_y(nrm_y), .nrm_z(nrm_z),
		.index_outside(index_outside), .index_inside(index_inside),
		.q_full(q_full), .q_push(q_push), .q_item(q_wdata)
	);

	snr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .wdata(q_wdata),
		.full(q_full), .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
	);

	snr_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_item(q_rdata),
		.q_pop(q_pop), .pop(pop), .empty(empty),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.total_internal(total_internal)
	);

endmodule

### design/snr_checker.sv
// Port-level checks for the refraction block, attached by bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module snr_port_props (
	input logic               clk,
	input logic               arst_n,
	input logic               full,
	input logic               pop,
	input logic               empty,
	input logic signed [15:0] out_x,
	input logic signed [15:0] out_y,
	input logic signed [15:0] out_z,
	input logic               total_internal
);

	// a reflected ray carries a zero vector
	`SNR_ASSERT_IMP(a_tir_zero, !empty && total_internal, out_x == 0 && out_y == 0 && out_z == 0)

	// a waiting result is not replaced before it is taken
	`SNR_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(out_x) && $stable(total_internal))

	// nothing is offered while in reset
	`SNR_ASSERT_ALW(a_rst_empty, !arst_n, empty && !full)

endmodule

bind snell_refraction_vector snr_port_props u_chk (.*);

### dv/snr_checker.sv
// Checker for the refraction pipeline: watches the input and result sides, predicts each result.
// Self-contained; connected beside snell_refraction_vector by tb_top.
`timescale 1ns / 1ps
module snr_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic signed [15:0] inc_x,
	input  logic signed [15:0] inc_y,
	input  logic signed [15:0] inc_z,
	input  logic signed [15:0] nrm_x,
	input  logic signed [15:0] nrm_y,
	input  logic signed [15:0] nrm_z,
	input  logic [14:0]        index_outside,
	input  logic [14:0]        index_inside,
	input  logic               pop,
	input  logic               empty,
	input  logic signed [15:0] out_x,
	input  logic signed [15:0] out_y,
	input  logic signed [15:0] out_z,
	input  logic               total_internal,
	output int                 errors,
	output int                 pending
);

	typedef struct {
		logic signed [15:0] x, y, z;
		logic               tir;
	} refr_t;

	refr_t refr_q[$];

	// floor square root, bit by bit
	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// refracted direction of one hit
	function automatic refr_t refract(input logic signed [15:0] ax, ay, az, nx, ny, nz,
			input logic [14:0] idx_out, idx_in);
		refr_t           r;
		longint          a[3], n[3], cosi, coef, sum, rd, sq;
		longint unsigned ei, et, tmp, ratio, c, s28, r2, prod;
		logic            tir;
		a[0] = ax; a[1] = ay; a[2] = az;
		n[0] = nx; n[1] = ny; n[2] = nz;
		ei = idx_out;
		et = idx_in;
		cosi = a[0] * n[0] + a[1] * n[1] + a[2] * n[2];
		if (cosi > (64'sd1 <<< 28)) cosi = 64'sd1 <<< 28;
		if (cosi < -(64'sd1 <<< 28)) cosi = -(64'sd1 <<< 28);
		// leaving the material (zero included): swap indices, flip normal
		if (cosi < 0) begin
			cosi = -cosi;
		end else begin
			tmp = ei; ei = et; et = tmp;
			for (int i = 0; i < 3; i++) n[i] = -n[i];
		end
		if (et == 0) et = 1;
		ratio = (ei << 16) / et;
		c = cosi;
		s28 = ((64'd1 << 56) - c * c) >> 28;
		r2 = (ratio * ratio) >> 16;
		tir = 1'b0;
		prod = 0;
		if (s28 != 0 && r2 > 64'hFFFF_FFFF_FFFF_FFFF / s28) begin
			tir = 1'b1;
		end else begin
			prod = (r2 * s28) >> 16;
			if (prod > (64'd1 << 28)) tir = 1'b1;
		end
		r.tir = tir;
		if (tir) begin
			r.x = '0; r.y = '0; r.z = '0;
			return r;
		end
		sq = longint'(floor_root((64'd1 << 28) - prod));
		coef = longint'((ratio * c) >> 16) - sq * 16384;
		for (int i = 0; i < 3; i++) begin
			sum = a[i] * longint'(ratio) * 4096 + n[i] * coef;
			rd = (sum + (64'sd1 <<< 27)) >>> 28;
			if (rd > 32767) rd = 32767;
			if (rd < -32768) rd = -32768;
			a[i] = rd;
		end
		r.x = a[0][15:0]; r.y = a[1][15:0]; r.z = a[2][15:0];
		return r;
	endfunction

	// result side first, then the incoming transaction
	always @(posedge clk or negedge arst_n) begin
		refr_t e;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
			refr_q.delete();
		end else begin
			if (pop && !empty) begin
				if (refr_q.size() == 0) begin
					$error("result transaction with nothing expected");
					errors <= errors + 1;
				end else begin
					e = refr_q.pop_front();
					if (out_x !== e.x || out_y !== e.y || out_z !== e.z
							|| total_internal !== e.tir) begin
						if (out_x !== e.x) $error("out_x exp %0d got %0d", e.x, out_x);
						if (out_y !== e.y) $error("out_y exp %0d got %0d", e.y, out_y);
						if (out_z !== e.z) $error("out_z exp %0d got %0d", e.z, out_z);
						if (total_internal !== e.tir)
							$error("total_internal exp %0b got %0b", e.tir, total_internal);
						errors <= errors + 1;
					end
				end
			end
			if (push && !full)
				refr_q.push_back(refract(inc_x, inc_y, inc_z, nrm_x, nrm_y, nrm_z,
					index_outside, index_inside));
			pending <= refr_q.size();
		end
	end

endmodule

### dv/tb_top.sv
// Stimulus and verdict for snell_refraction_vector.
// Depends on the block and on snr_checker, which does all the predicting.
`timescale 1ns / 1ps
module tb_top;

	logic               clk, arst_n, push, full, pop, empty, total_internal;
	logic signed [15:0] inc_x, inc_y, inc_z, nrm_x, nrm_y, nrm_z;
	logic signed [15:0] out_x, out_y, out_z;
	logic [14:0]        index_outside, index_inside;
	int                 errors, pending;
	int                 send_idle, recv_idle, sent;
	logic               hold_off;

	snell_refraction_vector dut (.*);
	snr_checker u_chk (.*);

	always #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: random pop, forced low during the long hold-off
	always @(posedge clk)
		pop <= !hold_off && ($urandom_range(99) >= recv_idle);

	// long hold-off so the pipeline fills and stalls its input
	initial begin
		hold_off = 1'b0;
		wait (sent >= 950);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (200) @(posedge clk);
		hold_off <= 1'b0;
	end

	// one transaction, held until accepted; full read at the falling edge
	task automatic send_hit(input logic [15:0] ax, ay, az, nx, ny, nz,
			input logic [14:0] eo, ei);
		logic rdy;
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		inc_x <= ax; inc_y <= ay; inc_z <= az;
		nrm_x <= nx; nrm_y <= ny; nrm_z <= nz;
		index_outside <= eo; index_inside <= ei;
		do begin
			@(negedge clk);
			rdy = !full;
			@(posedge clk);
		end while (!rdy);
		sent++;
	endtask

	task automatic send_random();
		logic [15:0] v[6];
		logic [14:0] eo, ei;
		if ($urandom_range(99) < 30) begin
			foreach (v[i]) v[i] = 16'($urandom);
			eo = 15'($urandom);
			ei = 15'($urandom);
		end else begin
			// direction components within plus or minus one, indices in the usual range
			foreach (v[i]) v[i] = 16'($urandom_range(32768) - 16384);
			eo = 15'($urandom_range(32767, 4096));
			ei = 15'($urandom_range(32767, 4096));
		end
		send_hit(v[0], v[1], v[2], v[3], v[4], v[5], eo, ei);
	endtask

	initial begin
		clk = 0; arst_n = 0; push = 0; sent = 0;
		inc_x = 0; inc_y = 0; inc_z = 0; nrm_x = 0; nrm_y = 0; nrm_z = 0;
		index_outside = 0; index_inside = 0;
		send_idle = 12; recv_idle = 57;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: entering, leaving, grazing, clamp, saturation, zero indices
		send_hit(0, 0, -16384, 0, 0, 16384, 8192, 12288);
		send_hit(0, 0, 16384, 0, 0, 16384, 12288, 8192);
		send_hit(16384, 0, 0, 0, 0, 16384, 8192, 12288);
		send_hit(16384, 0, 0, 0, 0, 16384, 12288, 8192);
		send_hit(11585, 0, -11585, 0, 0, 16384, 16384, 8192);
		send_hit(11585, 0, 11585, 0, 0, 16384, 8192, 16384);
		send_hit(-32768, -32768, -32768, 32767, 32767, 32767, 32767, 4096);
		send_hit(32767, 32767, 32767, 32767, 32767, 32767, 4096, 32767);
		send_hit(-32768, 32767, -32768, -32768, -32768, -32768, 32767, 32767);
		send_hit(32767, -32768, 0, 32767, 32767, 0, 32767, 4096);
		send_hit(5000, 3000, -15000, 0, 0, 16384, 0, 8192);
		send_hit(5000, 3000, 15000, 0, 0, 16384, 0, 8192);
		send_hit(5000, 3000, -15000, 0, 0, 16384, 8192, 0);
		send_hit(5000, 3000, 15000, 0, 0, 16384, 8192, 0);
		send_hit(0, 0, 0, 0, 0, 0, 0, 0);
		send_hit(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767);
		send_hit(9459, 9459, -9459, 9459, -9459, 9459, 8192, 10923);
		send_hit(100, -50, -16000, 200, 0, 16380, 32767, 32767);
		send_hit(16384, 16384, 0, -16384, 0, 0, 4096, 4096);
		send_hit(0, 1, -1, 0, 0, 1, 8192, 8192);

		// sender dense, receiver sparse
		while (sent < 450) send_random();
		push <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
		send_idle = 57; recv_idle = 12;
		while (sent < 900) send_random();
		push <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
		send_idle = 0; recv_idle = 0;
		while (sent < 1370) send_random();
		push <= 1'b0;
		@(posedge clk);

		wait (pending == 0);
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
